// ===== hw/rtl/utf8_stream_validator_core_assert.svh =====
// Assertion macros for the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define UTF8V_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("utf8 validator: assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define UTF8V_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("utf8 validator: assertion failed");
`else
`define UTF8V_ASSERT(label, prop)
`define UTF8V_ASSERT_NEXT(label, trig, cons)
`endif
`endif

// ===== hw/rtl/utf8v_pkg.sv =====
// Types and byte-class constants shared by the UTF-8 validator modules.
`default_nettype none
package utf8v_pkg;

	localparam logic [7:0] ASCII_MAX      = 8'h7F;
	localparam logic [2:0] LEAD2_TAG      = 3'h6;
	localparam logic [7:0] LEAD2_MIN      = 8'hC2;
	localparam logic [3:0] LEAD3_TAG      = 4'hE;
	localparam logic [4:0] LEAD4_TAG      = 5'h1E;
	localparam logic [7:0] LEAD4_MAX      = 8'hF4;
	localparam logic [1:0] CONT_TAG       = 2'h2;
	localparam logic [7:0] SURR_LEAD      = 8'hED;
	localparam logic [7:0] SURR_MASK      = 8'hE0;
	localparam logic [7:0] SURR_CONT      = 8'hA0;
	localparam logic [7:0] NUL_BYTE       = 8'h00;

	localparam logic [1:0] PEND_NONE      = 2'd0;
	localparam logic [1:0] PEND_ONE       = 2'd1;
	localparam logic [1:0] PEND_TWO       = 2'd2;
	localparam logic [1:0] PEND_THREE     = 2'd3;

	// Scan state carried from word to word.
	typedef struct packed {
		logic [1:0] pending;
		logic       surr_pending;
		logic       error_seen;
		logic       nul_stop;
	} scan_state_t;

	typedef struct packed {
		logic verdict_final;
		logic is_valid;
	} verdict_t;

	localparam scan_state_t SCAN_IDLE = '{pending: PEND_NONE, surr_pending: 1'b0,
		error_seen: 1'b0, nul_stop: 1'b0};

endpackage
`default_nettype wire

// ===== hw/rtl/utf8v_step.sv =====
// Per-word UTF-8 decode step: next scan state and the verdict for one word.
`default_nettype none
module utf8v_step (
	input  wire logic [7:0]          text_byte,
	input  wire logic                end_of_string,
	input  wire utf8v_pkg::scan_state_t cur,
	output utf8v_pkg::scan_state_t   nxt,
	output utf8v_pkg::verdict_t      verdict
);

	utf8v_pkg::scan_state_t upd;

	always_comb begin
		upd = cur;
		priority if (cur.error_seen || cur.nul_stop) begin
			// hold: checking is over until the end of the string
			upd = cur;
		end else if (cur.pending != utf8v_pkg::PEND_NONE) begin
			priority if (text_byte[7:6] != utf8v_pkg::CONT_TAG) begin
				upd.error_seen = 1'b1;
			end else if (cur.surr_pending &&
					((text_byte & utf8v_pkg::SURR_MASK) == utf8v_pkg::SURR_CONT)) begin
				upd.error_seen = 1'b1;
			end else begin
				upd.surr_pending = 1'b0;
				upd.pending      = cur.pending - 2'd1;
			end
		end else if (text_byte == utf8v_pkg::NUL_BYTE) begin
			upd.nul_stop = 1'b1;
		end else if (text_byte <= utf8v_pkg::ASCII_MAX) begin
			upd = cur;
		end else if (text_byte[7:5] == utf8v_pkg::LEAD2_TAG) begin
			if (text_byte < utf8v_pkg::LEAD2_MIN) begin
				upd.error_seen = 1'b1;
			end else begin
				upd.pending = utf8v_pkg::PEND_ONE;
			end
		end else if (text_byte[7:4] == utf8v_pkg::LEAD3_TAG) begin
			upd.pending      = utf8v_pkg::PEND_TWO;
			upd.surr_pending = (text_byte == utf8v_pkg::SURR_LEAD);
		end else if (text_byte[7:3] == utf8v_pkg::LEAD4_TAG) begin
			if (text_byte > utf8v_pkg::LEAD4_MAX) begin
				upd.error_seen = 1'b1;
			end else begin
				upd.pending = utf8v_pkg::PEND_THREE;
			end
		end else begin
			// stray continuation or F8..FF
			upd.error_seen = 1'b1;
		end
	end

	always_comb begin
		if (end_of_string) begin
			verdict.verdict_final = 1'b1;
			verdict.is_valid      = !upd.error_seen &&
				(upd.nul_stop || (upd.pending == utf8v_pkg::PEND_NONE));
			// restart for the next string
			nxt                   = utf8v_pkg::SCAN_IDLE;
		end else begin
			verdict.verdict_final = 1'b0;
			verdict.is_valid      = !upd.error_seen;
			nxt                   = upd;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_stream_validator_core.sv =====
// Top level of the UTF-8 stream validator: input register, scan state, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  byte    | in        | byte_valid / byte_stall    | text_byte[7:0], end_of_string
//  result  | out       | result_valid / result_stall| verdict_final, is_valid
//
// One word per clock unless the result stalls; the result register holds each verdict.
// The decode step between the input register and the result register sets the clock.
// arst_n clears both valid flags and the scan state; the next word opens a new string.
// A stalled result keeps the input register full, and byte_stall then rises.
// Each string ends on the word marked end_of_string, which carries the final verdict.
`default_nettype none
`include "utf8_stream_validator_core_assert.svh"
module utf8_stream_validator_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_string,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            verdict_final,
	output logic            is_valid
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	utf8v_pkg::scan_state_t state_q;
	utf8v_pkg::scan_state_t state_nxt;
	utf8v_pkg::verdict_t    verdict_nxt;
	utf8v_pkg::verdict_t    verdict_s2;
	logic                   valid_s2;
	logic                   advance;
	logic                   take_in;

	// advance the input stage when the result register is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign take_in    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_string;
		end
	end

	utf8v_step u_step (
		.text_byte     (byte_s1),
		.end_of_string (last_s1),
		.cur           (state_q),
		.nxt           (state_nxt),
		.verdict       (verdict_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= utf8v_pkg::SCAN_IDLE;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2 <= verdict_nxt;
		end
	end

	assign result_valid  = valid_s2;
	assign verdict_final = verdict_s2.verdict_final;
	assign is_valid      = verdict_s2.is_valid;

	`UTF8V_ASSERT_NEXT(a_restart_after_final, advance && last_s1,
		state_q == utf8v_pkg::SCAN_IDLE)
	`UTF8V_ASSERT_NEXT(a_error_latched, state_q.error_seen && !(advance && last_s1),
		state_q.error_seen)
	`UTF8V_ASSERT(a_no_error_and_nul, !(state_q.error_seen && state_q.nul_stop))
	`UTF8V_ASSERT(a_stall_only_when_full, byte_stall |-> (valid_s1 && valid_s2))
	`UTF8V_ASSERT_NEXT(a_error_reports_invalid, advance && state_nxt.error_seen,
		result_valid && !is_valid)

endmodule
`default_nettype wire

// ===== dv/utf8_stream_validator_core_checker.sv =====
// Scoreboard for the UTF-8 stream validator: predicts each verdict and checks the result channel.
`timescale 1ns / 100ps
module utf8_stream_validator_core_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_string,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic       verdict_final,
	input  logic       is_valid,
	output int         fail_count,
	output int         outstanding,
	output int         words_checked,
	output int         strings_ok,
	output int         strings_bad
);

	typedef struct {
		utf8v_pkg::verdict_t verdict;
		int                  index;
		logic [7:0]          text;
	} due_verdict_t;

	due_verdict_t           due_verdicts[$];
	utf8v_pkg::scan_state_t scan;
	int                     words_taken;

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	// Advance the scan state by one word and return the verdict it should produce.
	function automatic utf8v_pkg::verdict_t scan_word(input logic [7:0] b, input logic last);
		utf8v_pkg::verdict_t v;
		if (!scan.error_seen && !scan.nul_stop) begin
			if (scan.pending != utf8v_pkg::PEND_NONE) begin
				if (b[7:6] != utf8v_pkg::CONT_TAG)
					scan.error_seen = 1'b1;
				else if (scan.surr_pending &&
						(b & utf8v_pkg::SURR_MASK) == utf8v_pkg::SURR_CONT)
					scan.error_seen = 1'b1;
				else begin
					scan.surr_pending = 1'b0;
					scan.pending = scan.pending - 2'd1;
				end
			end else if (b == utf8v_pkg::NUL_BYTE) begin
				scan.nul_stop = 1'b1;
			end else if (b <= utf8v_pkg::ASCII_MAX) begin
				// single-byte character, nothing opens
			end else if (b[7:5] == utf8v_pkg::LEAD2_TAG) begin
				if (b < utf8v_pkg::LEAD2_MIN)
					scan.error_seen = 1'b1;
				else
					scan.pending = utf8v_pkg::PEND_ONE;
			end else if (b[7:4] == utf8v_pkg::LEAD3_TAG) begin
				scan.pending = utf8v_pkg::PEND_TWO;
				scan.surr_pending = (b == utf8v_pkg::SURR_LEAD);
			end else if (b[7:3] == utf8v_pkg::LEAD4_TAG) begin
				if (b > utf8v_pkg::LEAD4_MAX)
					scan.error_seen = 1'b1;
				else
					scan.pending = utf8v_pkg::PEND_THREE;
			end else begin
				scan.error_seen = 1'b1;
			end
		end
		if (last) begin
			v.verdict_final = 1'b1;
			v.is_valid = !scan.error_seen &&
				(scan.nul_stop || scan.pending == utf8v_pkg::PEND_NONE);
			scan = utf8v_pkg::SCAN_IDLE;
		end else begin
			v.verdict_final = 1'b0;
			v.is_valid = !scan.error_seen;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		due_verdict_t due;
		if (!arst_n) begin
			due_verdicts.delete();
			scan = utf8v_pkg::SCAN_IDLE;
			fail_count = 0;
			outstanding = 0;
			words_checked = 0;
			words_taken = 0;
			strings_ok = 0;
			strings_bad = 0;
		end else begin
			// Check the result side first: a word taken at this edge cannot have its verdict yet.
			if (result_valid && !result_stall) begin
				if (due_verdicts.size() == 0) begin
					report_mismatch($sformatf("verdict (%b,%b) with no word waiting",
						verdict_final, is_valid));
				end else begin
					due = due_verdicts.pop_front();
					words_checked++;
					if (verdict_final !== due.verdict.verdict_final)
						report_mismatch($sformatf("word %0d (byte %02h): verdict_final %b, want %b",
							due.index, due.text, verdict_final, due.verdict.verdict_final));
					if (is_valid !== due.verdict.is_valid)
						report_mismatch($sformatf("word %0d (byte %02h): is_valid %b, want %b",
							due.index, due.text, is_valid, due.verdict.is_valid));
					if (due.verdict.verdict_final) begin
						if (due.verdict.is_valid)
							strings_ok++;
						else
							strings_bad++;
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				due.verdict = scan_word(text_byte, end_of_string);
				due.index = words_taken;
				due.text = text_byte;
				due_verdicts.push_back(due);
				words_taken++;
			end
			outstanding = due_verdicts.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the UTF-8 stream validator: clock, reset, byte stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb;

	localparam int RANDOM_WORDS = 700;
	localparam int IDLE_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] text_byte;
	logic       end_of_string;
	logic       result_valid;
	logic       result_stall;
	logic       verdict_final;
	logic       is_valid;
	int         fail_count;
	int         outstanding;
	int         words_checked;
	int         strings_ok;
	int         strings_bad;

	logic [7:0] text_buf[$];
	int         words_sent;
	int         strings_sent;
	int         idle_cycles;
	bit         no_gaps;

	utf8_stream_validator_core u_top (.*);

	utf8_stream_validator_core_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Hold the word until taken; valid stays high for a following word.
	task automatic send_word(input logic [7:0] b, input logic last);
		byte_valid <= 1'b1;
		text_byte <= b;
		end_of_string <= last;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_text();
		int gap;
		foreach (text_buf[i]) begin
			send_word(text_buf[i], i == text_buf.size() - 1);
			gap = no_gaps ? 0 : pick_gap();
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		strings_sent++;
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic void add_char();
		logic [7:0] lead;
		case ($urandom_range(3))
			0: begin
				// occasional NUL, which stops the check where it starts a character
				text_buf.push_back($urandom_range(19) == 0 ? utf8v_pkg::NUL_BYTE
					: 8'($urandom_range(1, 127)));
			end
			1: begin
				text_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
				text_buf.push_back(cont_byte());
			end
			2: begin
				lead = ($urandom_range(3) == 0) ? utf8v_pkg::SURR_LEAD
					: 8'($urandom_range(8'hE0, 8'hEF));
				text_buf.push_back(lead);
				if (lead == utf8v_pkg::SURR_LEAD)
					text_buf.push_back($urandom_range(3) == 0 ? 8'($urandom_range(8'hA0, 8'hBF))
						: 8'($urandom_range(8'h80, 8'h9F)));
				else
					text_buf.push_back(cont_byte());
				text_buf.push_back(cont_byte());
			end
			default: begin
				text_buf.push_back(8'($urandom_range(8'hF0, 8'hF4)));
				repeat (3) text_buf.push_back(cont_byte());
			end
		endcase
	endfunction

	// Mostly well-formed strings with random content; some damaged, some pure noise.
	function automatic void build_text();
		int kind;
		int chars;
		int pos;
		text_buf.delete();
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom));
			return;
		end
		chars = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
		repeat (chars) add_char();
		if (kind < 32) begin
			case ($urandom_range(2))
				0: begin
					pos = $urandom_range(text_buf.size() - 1);
					text_buf[pos] = 8'($urandom);
				end
				1: begin
					repeat ($urandom_range(1, 2))
						if (text_buf.size() > 1)
							void'(text_buf.pop_back());
				end
				default: begin
					pos = $urandom_range(text_buf.size());
					text_buf.insert(pos, 8'($urandom));
				end
			endcase
		end
	endfunction

	// Receiver: random stalls, with stretches of none.
	initial begin
		int n;
		result_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(99) < 15 ? 40 : $urandom_range(1, 4)) @(posedge clk);
		end
	end

	// Drop the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("utf8_stream_validator_core regression: fail");
			$finish;
		end
	end

	initial begin
		int random_start;
		bit paused;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		text_byte <= 8'h00;
		end_of_string <= 1'b0;
		words_sent = 0;
		strings_sent = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// NUL stop, then bytes that must be ignored
		text_buf = '{8'h00, 8'hFF};
		send_text();
		// valid mix: ASCII max, two-byte, ED below surrogates, four-byte at F4
		text_buf = '{8'h7F, 8'hC2, 8'h80, 8'hED, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text();
		// bad two-byte lead, rest ignored
		text_buf = '{8'hC0, 8'h41};
		send_text();
		text_buf = '{8'hC1};
		send_text();
		// surrogate after ED
		text_buf = '{8'hED, 8'hA0};
		send_text();
		// lead above F4, all-ones byte, stray continuation
		text_buf = '{8'hF5};
		send_text();
		text_buf = '{8'hFF};
		send_text();
		text_buf = '{8'h80};
		send_text();
		// truncated at the end
		text_buf = '{8'hE2, 8'h82};
		send_text();
		// NUL in a continuation slot
		text_buf = '{8'hC2, 8'h00};
		send_text();
		text_buf = '{8'h41};
		send_text();

		random_start = words_sent;
		while (words_sent - random_start < RANDOM_WORDS) begin
			build_text();
			no_gaps = ($urandom_range(3) == 0);
			send_text();
			// once, drain everything before going on
			if (!paused && words_sent - random_start >= RANDOM_WORDS / 2) begin
				byte_valid <= 1'b0;
				// let the scoreboard log the last word before looking at its queue
				@(posedge clk);
				wait (outstanding == 0);
				@(posedge clk);
				paused = 1'b1;
			end
		end
		byte_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (6) @(posedge clk);

		$display("covered %0d words in %0d strings, %0d verdicts checked",
			words_sent, strings_sent, words_checked);
		$display("final verdicts: %0d valid, %0d rejected", strings_ok, strings_bad);
		if (outstanding != 0)
			$display("%0d words never got a verdict", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("utf8_stream_validator_core regression: pass");
		else
			$display("utf8_stream_validator_core regression: fail");
		$finish;
	end

endmodule
